// ===== rtl/core/argmax_cost_matrix_mean_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cost-weighted top-1 error core
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef ARGMAX_COST_MATRIX_MEAN_CORE_MACROS_SVH
`define ARGMAX_COST_MATRIX_MEAN_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ACM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ACM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/acm_pkg.sv =====
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types and fixed field widths of the cost-weighted top-1 error core.
// ----------------------------------------------------------------------------
`default_nettype none

package acm_pkg;

   localparam int COST_W     = 16;  // Q8.8 table cost and mean
   localparam int SCORE_W    = 32;  // Q16.16 class score
   localparam int IDX_W      = 4;   // row, col and label fields
   localparam int CLS_CFG_W  = 5;   // class-count register
   localparam int CNT_PORT_W = 17;  // position_count field

   localparam logic                 REQ_TABLE   = 1'b0;
   localparam logic                 REQ_SCORE   = 1'b1;
   localparam logic [CLS_CFG_W-1:0] CLS_CFG_RST = 5'd16;

   // divider handshake status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/acm_table.sv =====
// ----------------------------------------------------------------------------
// acm_table
// Distance table: single-port-write, single-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_table
   import acm_pkg::*;
#(
   parameter int ADDR_W = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [COST_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [COST_W-1:0] rd_data
);

   localparam int DEPTH = 2 ** ADDR_W;

   logic [COST_W-1:0] mem_ff [DEPTH];
   logic [COST_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/acm_div.sv =====
// ----------------------------------------------------------------------------
// acm_div
// Radix-2 restoring divider: signed sum by unsigned count, truncated to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_div
   import acm_pkg::*;
#(
   parameter int SUM_W = 33,
   parameter int CNT_W = 17
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SUM_W-1:0]  dividend,
   input  wire logic [CNT_W-1:0]  divisor,
   output div_status_type         status,
   output logic      [COST_W-1:0] quotient
);

   localparam int ITER_W = $clog2(SUM_W + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_DONE} state_type;

   state_type         state_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  dvs_ff;
   logic              neg_ff;

   logic [CNT_W:0]    trial;
   logic              fits;
   logic [CNT_W:0]    diff;
   logic [COST_W-1:0] mag;

   // one quotient bit per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      fits  = trial >= {1'b0, dvs_ff};
      diff  = trial - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE, ST_DONE: begin
               if (start) begin
                  state_ff <= ST_BUSY;
                  iter_ff  <= ITER_W'(SUM_W);
                  neg_ff   <= dividend[SUM_W-1];
                  quo_ff   <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
                  rem_ff   <= '0;
                  dvs_ff   <= divisor;
               end
            end
            ST_BUSY: begin
               quo_ff  <= {quo_ff[SUM_W-2:0], fits};
               rem_ff  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
               iter_ff <= iter_ff - 1'b1;
               if (iter_ff == ITER_W'(1)) begin
                  state_ff <= ST_DONE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign mag         = quo_ff[COST_W-1:0];
   assign status.busy = (state_ff == ST_BUSY);
   assign status.done = (state_ff == ST_DONE);
   // empty batch gives zero
   assign quotient    = (dvs_ff == '0) ? '0 : (neg_ff ? (~mag + 1'b1) : mag);

endmodule

`default_nettype wire

// ===== rtl/core/argmax_cost_matrix_mean_core.sv =====
// ----------------------------------------------------------------------------
// argmax_cost_matrix_mean_core
// Cost-weighted top-1 error: per-position arg-max, table cost lookup, batch mean.
// ----------------------------------------------------------------------------
// Table-load transfers (req_type 0) write one cost into the MAX_LABELS x
// MAX_LABELS distance table; score transfers (req_type 1) stream in class
// order, one per class in use, per position. Both are taken one per cycle
// while the core is not stalled. The arg-max (ties go to the higher class)
// is tracked in registers; when a position completes, the table entry for
// (arg-max, true label) is read from the memory and added to the running sum
// on the following cycle. A position whose true_label is at or above the
// class count sets label_error and is not counted; positions beyond
// MAX_POSITIONS set overflow and are dropped. On the position flagged
// last_position the core stops taking transfers while it folds the last cost
// into the sum, runs the one-bit-per-cycle restoring divider and moves the
// mean into the output register. If the previous result still waits in that
// register, the stall lasts until it is taken.
// The result then waits in that register while the next batch streams in.
// The table has no reset: reading an entry never written returns whatever the
// memory holds. Write the class count only while the core is idle; 0 acts as
// 1 and values above MAX_LABELS clamp.
// ----------------------------------------------------------------------------
`default_nettype none

`include "argmax_cost_matrix_mean_core_macros.svh"

module argmax_cost_matrix_mean_core
   import acm_pkg::*;
#(
   parameter int MAX_LABELS    = 16,
   parameter int MAX_POSITIONS = 65536
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // config
   input  wire logic                    csr_wr_en,
   input  wire logic [CLS_CFG_W-1:0]    csr_wr_data,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_type,
   input  wire logic [IDX_W-1:0]        req_table_row,
   input  wire logic [IDX_W-1:0]        req_table_col,
   input  wire logic signed [COST_W-1:0] req_table_value,
   input  wire logic signed [SCORE_W-1:0] req_score,
   input  wire logic [IDX_W-1:0]        req_true_label,
   input  wire logic                    req_last_position,
   // response channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [COST_W-1:0]     rsp_mean_distance,
   output logic [CNT_PORT_W-1:0]        rsp_position_count,
   output logic                         rsp_label_error,
   output logic                         rsp_overflow
);

   localparam int CLS_W  = $clog2(MAX_LABELS);
   localparam int EFF_W  = ($clog2(MAX_LABELS + 1) > CLS_CFG_W) ?
                           $clog2(MAX_LABELS + 1) : CLS_CFG_W;
   localparam int CNT_W  = $clog2(MAX_POSITIONS + 1);
   localparam int SUM_W  = COST_W + CNT_W;
   localparam int ADDR_W = 2 * CLS_W;

   typedef enum logic [1:0] {ST_RUN, ST_LOAD, ST_DIV} state_type;

   // ---------------- registers ----------------
   state_type                   state_ff,       state_in;
   logic [CLS_CFG_W-1:0]        class_cfg_ff,   class_cfg_in;
   logic signed [SCORE_W-1:0]   best_score_ff,  best_score_in;
   logic [CLS_W-1:0]            best_class_ff,  best_class_in;
   logic [CLS_W-1:0]            cls_cnt_ff,     cls_cnt_in;
   logic signed [SUM_W-1:0]     cost_sum_ff,    cost_sum_in;
   logic [CNT_W-1:0]            count_ff,       count_in;
   logic                        lbl_err_ff,     lbl_err_in;
   logic                        ovf_ff,         ovf_in;
   logic                        add_pend_ff,    add_pend_in;
   logic [CNT_W-1:0]            snap_count_ff,  snap_count_in;
   logic                        snap_lbl_ff,    snap_lbl_in;
   logic                        snap_ovf_ff,    snap_ovf_in;
   logic                        rsp_valid_ff,   rsp_valid_in;
   logic [COST_W-1:0]           rsp_mean_ff,    rsp_mean_in;
   logic [CNT_PORT_W-1:0]       rsp_count_ff,   rsp_count_in;
   logic                        rsp_lbl_ff,     rsp_lbl_in;
   logic                        rsp_ovf_ff,     rsp_ovf_in;

   // ---------------- datapath nets ----------------
   logic                        req_xfer;
   logic                        score_xfer;
   logic [EFF_W-1:0]            n_eff;
   logic                        take_new;
   logic [CLS_W-1:0]            bc_new;
   logic                        pos_done;
   logic                        lbl_bad;
   logic                        at_cap;
   logic                        counted;
   logic                        tbl_wr_en;
   logic [ADDR_W-1:0]           tbl_wr_addr;
   logic                        tbl_rd_en;
   logic [ADDR_W-1:0]           tbl_rd_addr;
   logic [COST_W-1:0]           tbl_rd_data;
   logic signed [SUM_W-1:0]     cost_ext;
   logic signed [SUM_W-1:0]     sum_folded;
   logic                        div_start;
   div_status_type              div_status;
   logic [COST_W-1:0]           div_quo;
   logic                        rsp_free;

   assign req_ready  = (state_ff == ST_RUN);
   assign req_xfer   = req_valid && req_ready;
   assign score_xfer = req_xfer && (req_type == REQ_SCORE);

   // clamp the class count into 1..MAX_LABELS
   always_comb begin
      priority if (class_cfg_ff == '0) begin
         n_eff = EFF_W'(1);
      end else if (EFF_W'(class_cfg_ff) > EFF_W'(MAX_LABELS)) begin
         n_eff = EFF_W'(MAX_LABELS);
      end else begin
         n_eff = EFF_W'(class_cfg_ff);
      end
   end

   // arg-max: >= so ties move to the later (higher) class
   assign take_new = (cls_cnt_ff == '0) || (req_score >= best_score_ff);
   assign bc_new   = take_new ? cls_cnt_ff : best_class_ff;
   assign pos_done = (EFF_W'(cls_cnt_ff) + EFF_W'(1)) >= n_eff;
   assign lbl_bad  = EFF_W'(req_true_label) >= n_eff;
   assign at_cap   = count_ff >= CNT_W'(MAX_POSITIONS);
   assign counted  = score_xfer && pos_done && !lbl_bad && !at_cap;

   // table access; a read and a write never share a cycle
   assign tbl_wr_en   = req_xfer && (req_type == REQ_TABLE)
                        && (int'(req_table_row) < MAX_LABELS)
                        && (int'(req_table_col) < MAX_LABELS);
   assign tbl_wr_addr = {CLS_W'(req_table_row), CLS_W'(req_table_col)};
   assign tbl_rd_en   = counted;
   assign tbl_rd_addr = {bc_new, CLS_W'(req_true_label)};

   assign cost_ext   = {{(SUM_W-COST_W){tbl_rd_data[COST_W-1]}}, tbl_rd_data};
   assign sum_folded = add_pend_ff ? (cost_sum_ff + cost_ext) : cost_sum_ff;
   assign div_start  = (state_ff == ST_LOAD);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      class_cfg_in  = csr_wr_en ? csr_wr_data : class_cfg_ff;
      best_score_in = best_score_ff;
      best_class_in = best_class_ff;
      cls_cnt_in    = cls_cnt_ff;
      cost_sum_in   = sum_folded;
      count_in      = count_ff;
      lbl_err_in    = lbl_err_ff;
      ovf_in        = ovf_ff;
      add_pend_in   = counted;
      snap_count_in = snap_count_ff;
      snap_lbl_in   = snap_lbl_ff;
      snap_ovf_in   = snap_ovf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_mean_in   = rsp_mean_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_lbl_in    = rsp_lbl_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      unique case (state_ff)
         ST_RUN: begin
            if (score_xfer) begin
               if (!pos_done) begin
                  best_score_in = take_new ? req_score : best_score_ff;
                  best_class_in = bc_new;
                  cls_cnt_in    = cls_cnt_ff + 1'b1;
               end else begin
                  best_score_in = '0;
                  best_class_in = '0;
                  cls_cnt_in    = '0;
                  priority if (lbl_bad) begin
                     lbl_err_in = 1'b1;
                  end else if (at_cap) begin
                     ovf_in = 1'b1;
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
                  if (req_last_position) begin
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_LOAD: begin
            // last cost folds in here; snapshot and clear the batch
            snap_count_in = count_ff;
            snap_lbl_in   = lbl_err_ff;
            snap_ovf_in   = ovf_ff;
            cost_sum_in   = '0;
            count_in      = '0;
            lbl_err_in    = 1'b0;
            ovf_in        = 1'b0;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done && rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = div_quo;
               rsp_count_in = CNT_PORT_W'(snap_count_ff);
               rsp_lbl_in   = snap_lbl_ff;
               rsp_ovf_in   = snap_ovf_ff;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         class_cfg_ff  <= CLS_CFG_RST;
         best_score_ff <= '0;
         best_class_ff <= '0;
         cls_cnt_ff    <= '0;
         cost_sum_ff   <= '0;
         count_ff      <= '0;
         lbl_err_ff    <= 1'b0;
         ovf_ff        <= 1'b0;
         add_pend_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         class_cfg_ff  <= class_cfg_in;
         best_score_ff <= best_score_in;
         best_class_ff <= best_class_in;
         cls_cnt_ff    <= cls_cnt_in;
         cost_sum_ff   <= cost_sum_in;
         count_ff      <= count_in;
         lbl_err_ff    <= lbl_err_in;
         ovf_ff        <= ovf_in;
         add_pend_ff   <= add_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      snap_count_ff <= snap_count_in;
      snap_lbl_ff   <= snap_lbl_in;
      snap_ovf_ff   <= snap_ovf_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_lbl_ff    <= rsp_lbl_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   acm_table #(
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (req_table_value),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   acm_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_folded),
      .divisor  (count_ff),
      .status   (div_status),
      .quotient (div_quo)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mean_distance  = rsp_mean_ff;
   assign rsp_position_count = rsp_count_ff;
   assign rsp_label_error    = rsp_lbl_ff;
   assign rsp_overflow       = rsp_ovf_ff;

   // ---------------- assertions ----------------
   `ACM_ASSERT_SAME(a_add_after_read, clock, reset, add_pend_ff, $past(tbl_rd_en),
      "cost fold without a table read in the previous cycle")
   `ACM_ASSERT_NEXT(a_last_to_load, clock, reset,
      score_xfer && pos_done && req_last_position, state_ff == ST_LOAD,
      "batch end did not enter the fold cycle")
   `ACM_ASSERT_NEXT(a_load_clears, clock, reset, state_ff == ST_LOAD,
      (state_ff == ST_DIV) && (count_ff == '0) && (cost_sum_ff == '0) && div_status.busy,
      "batch accumulators not cleared or divider not started")
   `ACM_ASSERT_SAME(a_count_cap, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_POSITIONS),
      "position count above capacity")

endmodule

`default_nettype wire
